### rtl/rlte_pkg.sv
// shared types and constants for the run-length text expander
// no dependencies; used by rlte_ctrl, rlte_dp and the top level
package rlte_pkg;

  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;
  localparam int unsigned Radix = 10;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusLeadDigit = 2'd1;
  localparam logic [1:0] StatusTooShort = 2'd2;

  localparam logic RegMaxLength = 1'b0;
  localparam logic RegMinLength = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StProc,
    StLoadRep,
    StRep,
    StSym,
    StStat
  } rlte_state_e;

  typedef struct packed {
    logic latch;
    logic start;
    logic count;
    logic load_rep;
    logic emit_rep;
    logic emit_sym;
    logic emit_stat;
  } rlte_cmd_t;

  typedef struct packed {
    logic started;
    logic digit;
    logic eos;
    logic active;
    logic rep_zero;
    logic rep_last;
    logic out_free;
  } rlte_sts_t;

endpackage

### rtl/rlte_ctrl.sv
// sequencing state machine for the run-length text expander
// depends on rlte_pkg; drives commands into rlte_dp and reads its status
module rlte_ctrl import rlte_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  rlte_sts_t sts_i,
  output rlte_cmd_t cmd_o
);

  rlte_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StProc;
      end
      StProc: begin
        if (!sts_i.started) begin
          if (sts_i.digit) state_d = sts_i.eos ? StStat : StIdle;
          else state_d = StSym;
        end else if (sts_i.active) begin
          if (sts_i.digit) state_d = sts_i.eos ? StLoadRep : StIdle;
          else state_d = StLoadRep;
        end else begin
          state_d = sts_i.eos ? StStat : StIdle;
        end
      end
      StLoadRep: state_d = StRep;
      StRep: begin
        if (sts_i.rep_zero) begin
          state_d = sts_i.digit ? StStat : StSym;
        end else if (sts_i.out_free && sts_i.rep_last) begin
          state_d = StIdle;
        end
      end
      StSym: begin
        if (sts_i.out_free) state_d = StIdle;
      end
      StStat: begin
        if (sts_i.out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      StProc: begin
        if (!sts_i.started) cmd_o.start = 1'b1;
        else if (sts_i.active && sts_i.digit) cmd_o.count = 1'b1;
      end
      StLoadRep: cmd_o.load_rep = 1'b1;
      StRep: cmd_o.emit_rep = !sts_i.rep_zero && sts_i.out_free;
      StSym: cmd_o.emit_sym = sts_i.out_free;
      StStat: cmd_o.emit_stat = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

### rtl/rlte_dp.sv
// datapath of the run-length text expander: string state, run counter,
// length tracking, configuration registers and the output register; uses rlte_pkg
module rlte_dp import rlte_pkg::*; #(
  parameter int unsigned MAX_RUN = 64,
  parameter int unsigned MAX_STRING_LEN = 4095
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic [7:0]  ch_i,
  input  logic        eos_i,
  input  rlte_cmd_t   cmd_i,
  output rlte_sts_t   sts_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [7:0]  out_symbol_o,
  output logic        out_has_symbol_o,
  output logic        out_last_o,
  output logic        out_done_o,
  output logic [1:0]  out_status_o
);

  localparam int unsigned RW = $clog2(MAX_RUN + 1);
  localparam int unsigned LW = $clog2(MAX_STRING_LEN + 1);
  localparam int unsigned CW = ((LW > 12) ? LW : 12) + 1;
  localparam int unsigned VW = RW + 4;

  logic [11:0]   max_len_q, min_len_q;
  logic [7:0]    ch_q;
  logic          eos_q;
  logic [7:0]    prev_q;
  logic [RW-1:0] run_q, rep_q;
  logic [LW-1:0] len_q;
  logic          started_q, halted_q;
  logic [1:0]    err_q;
  logic          out_valid_q;
  logic [7:0]    out_symbol_q;
  logic          out_has_q, out_last_q, out_done_q;
  logic [1:0]    out_status_q;

  logic          digit, active, will_halt, out_free;
  logic [CW-1:0] len_inc;
  logic [VW-1:0] run_next;
  logic [1:0]    emit_status, stat_status;
  logic          emit_any, rep_last, emit_done;

  assign digit = (ch_q >= CharZero) && (ch_q <= CharNine);
  assign active = (err_q == StatusOk) && !halted_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign len_inc = CW'(len_q) + CW'(1);
  assign will_halt = ((max_len_q != '0) && (len_inc >= CW'(max_len_q)))
                     || (len_inc >= CW'(MAX_STRING_LEN));
  assign run_next = VW'(run_q) * VW'(Radix) + VW'(ch_q - CharZero);
  assign rep_last = will_halt || ((rep_q == RW'(1)) && digit);
  assign emit_any = cmd_i.emit_rep || cmd_i.emit_sym;
  assign emit_done = eos_q && (cmd_i.emit_sym || (cmd_i.emit_rep && rep_last));
  assign emit_status = (!will_halt && (len_inc < CW'(min_len_q))) ? StatusTooShort : StatusOk;
  assign stat_status = (err_q != StatusOk) ? err_q :
                       (!halted_q && (CW'(len_q) < CW'(min_len_q))) ? StatusTooShort :
                       StatusOk;

  always_comb begin
    sts_o.started  = started_q;
    sts_o.digit    = digit;
    sts_o.eos      = eos_q;
    sts_o.active   = active;
    sts_o.rep_zero = (rep_q == '0);
    sts_o.rep_last = rep_last;
    sts_o.out_free = out_free;
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= '0;
      min_len_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegMaxLength) max_len_q <= cfg_data_i;
      else min_len_q <= cfg_data_i;
    end
  end

  // input latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      ch_q  <= ch_i;
      eos_q <= eos_i;
    end
  end

  // string state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      run_q     <= '0;
      rep_q     <= '0;
      len_q     <= '0;
      started_q <= 1'b0;
      halted_q  <= 1'b0;
      err_q     <= StatusOk;
    end else begin
      if (cmd_i.start) begin
        started_q <= 1'b1;
        if (digit) err_q <= StatusLeadDigit;
      end
      if (cmd_i.count) begin
        run_q <= (run_next > VW'(MAX_RUN)) ? RW'(MAX_RUN) : run_next[RW-1:0];
      end
      if (cmd_i.load_rep) begin
        rep_q <= (run_q == '0) ? '0 : run_q - RW'(1);
      end
      if (cmd_i.emit_rep) begin
        rep_q <= rep_q - RW'(1);
      end
      if (emit_any) begin
        len_q <= len_inc[LW-1:0];
        if (will_halt) halted_q <= 1'b1;
      end
      if (cmd_i.emit_sym) begin
        prev_q <= ch_q;
        run_q  <= '0;
      end
      if (emit_done || cmd_i.emit_stat) begin
        prev_q    <= '0;
        run_q     <= '0;
        rep_q     <= '0;
        len_q     <= '0;
        started_q <= 1'b0;
        halted_q  <= 1'b0;
        err_q     <= StatusOk;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_any || cmd_i.emit_stat) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_any) begin
      out_symbol_q <= cmd_i.emit_sym ? ch_q : prev_q;
      out_has_q    <= 1'b1;
      out_last_q   <= cmd_i.emit_sym || rep_last;
      out_done_q   <= emit_done;
      out_status_q <= emit_done ? emit_status : StatusOk;
    end else if (cmd_i.emit_stat) begin
      out_symbol_q <= '0;
      out_has_q    <= 1'b0;
      out_last_q   <= 1'b1;
      out_done_q   <= 1'b1;
      out_status_q <= stat_status;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_symbol_o     = out_symbol_q;
  assign out_has_symbol_o = out_has_q;
  assign out_last_o       = out_last_q;
  assign out_done_o       = out_done_q;
  assign out_status_o     = out_status_q;

endmodule

### rtl/run_length_text_expander_top.sv
// run-length text expander top level: one character in, expanded symbols out
// a digit is latched and added to the run count; a letter closing a run emits
// the previous symbol's repeats and then itself; the output register takes one
// symbol per cycle unless the output stalls; one character is taken at a time
// reset clears the string state, the configuration registers and the output valid
// depends on rlte_pkg, rlte_ctrl and rlte_dp
module run_length_text_expander_top import rlte_pkg::*; #(
  parameter int unsigned MAX_RUN = 64,
  parameter int unsigned MAX_STRING_LEN = 4095
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // ch
  input  logic        s_axis_tlast,  // end_of_string
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // symbol, last, status, zero fill
  output logic        m_axis_tlast,  // string_done
  output logic        m_axis_tuser   // has_symbol
);

  rlte_cmd_t  cmd;
  rlte_sts_t  sts;
  logic [7:0] symbol;
  logic       last;
  logic [1:0] status;

  assign cfg_ready_o = 1'b1;

  rlte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rlte_dp #(
    .MAX_RUN        (MAX_RUN),
    .MAX_STRING_LEN (MAX_STRING_LEN)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .ch_i             (s_axis_tdata),
    .eos_i            (s_axis_tlast),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .out_symbol_o     (symbol),
    .out_has_symbol_o (m_axis_tuser),
    .out_last_o       (last),
    .out_done_o       (m_axis_tlast),
    .out_status_o     (status)
  );

  assign m_axis_tdata = {5'b0, status, last, symbol};

endmodule
